@@ hdl/nat_port_block_allocator_defines.svh @@
// assertion macros for the port block allocator
`ifndef NAT_PORT_BLOCK_ALLOCATOR_DEFINES_SVH
`define NAT_PORT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define NPBA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npba assertion failed");
`define NPBA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npba assertion failed");
`else
`define NPBA_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define NPBA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/npba_pkg.sv @@
// shared types and constants of the port block allocator
`default_nettype none

package npba_pkg;

    localparam int TRACK_DEPTH = 1024;
    localparam int TRACK_IDX_W = $clog2(TRACK_DEPTH);

    localparam logic [15:0] BLOCK_START_RST = 16'd1024;
    localparam logic [15:0] BLOCK_END_RST   = 16'd1535;
    localparam logic [31:0] HOLD_TIME_RST   = 32'd120000;

    localparam logic [1:0] REG_BLOCK_START = 2'd0;
    localparam logic [1:0] REG_BLOCK_END   = 2'd1;
    localparam logic [1:0] REG_HOLD_TIME   = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [31:0] stamp;
    } hold_entry_t;

    typedef struct packed {
        logic                   en;
        logic [TRACK_IDX_W-1:0] addr;
        hold_entry_t            data;
    } ram_wr_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE,
        ST_START,
        ST_RD,
        ST_CHK,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

@@ hdl/npba_hold_ram.sv @@
// hold stamp store, one write and one registered read per cycle
`default_nettype none

module npba_hold_ram (
    input  wire logic                            clk,
    input  wire npba_pkg::ram_wr_t               wr,
    input  wire logic [npba_pkg::TRACK_IDX_W-1:0] rd_addr,
    output npba_pkg::hold_entry_t                rd_data
);
    import npba_pkg::*;

    hold_entry_t mem [TRACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/nat_port_block_allocator.sv @@
// allocate: after the request is taken, the start state, then one store read and one compare for each
// port tried until a free port is found or the block is exhausted, then the result state posts it
// free: the free state, then the result state posts the result; one request in flight, not ready meanwhile
// next request taken the cycle after a result is posted
// after reset the hold store is swept clear, all 1024 entries, before the first request
// asynchronous active-low reset restores the register defaults and the cursor
`default_nettype none
`include "nat_port_block_allocator_defines.svh"

module nat_port_block_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // port[15:0], now_time[47:16]
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // port_out[15:0], ok[16], zero[23:17]
);
    import npba_pkg::*;

    state_t                 state_reg, state_next;
    logic [15:0]            start_reg, start_next;
    logic [15:0]            end_reg, end_next;
    logic [31:0]            hold_reg, hold_next;
    logic [15:0]            cursor_reg, cursor_next;
    logic [16:0]            remain_reg, remain_next;
    logic [TRACK_IDX_W-1:0] clr_reg, clr_next;
    logic                   tracked_reg, tracked_next;
    logic [15:0]            port_reg, port_next;
    logic [31:0]            now_reg, now_next;
    logic [15:0]            res_port_reg, res_port_next;
    logic                   res_ok_reg, res_ok_next;
    logic                   out_valid_reg, out_valid_next;
    logic [16:0]            out_data_reg, out_data_next;

    ram_wr_t                ram_wr;
    logic [TRACK_IDX_W-1:0] ram_rd_addr;
    hold_entry_t            ram_rd;

    logic [15:0]            cur_off;
    logic [15:0]            free_off;
    logic                   held;

    npba_hold_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    assign cur_off     = cursor_reg - start_reg;
    assign free_off    = port_reg - start_reg;
    assign ram_rd_addr = cur_off[TRACK_IDX_W-1:0];
    assign held        = tracked_reg && ram_rd.valid && ((now_reg - ram_rd.stamp) < hold_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            start_reg     <= BLOCK_START_RST;
            end_reg       <= BLOCK_END_RST;
            hold_reg      <= HOLD_TIME_RST;
            cursor_reg    <= BLOCK_START_RST;
            remain_reg    <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            hold_reg      <= hold_next;
            cursor_reg    <= cursor_next;
            remain_reg    <= remain_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tracked_reg  <= tracked_next;
        port_reg     <= port_next;
        now_reg      <= now_next;
        res_port_reg <= res_port_next;
        res_ok_reg   <= res_ok_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        hold_next      = hold_reg;
        cursor_next    = cursor_reg;
        remain_next    = remain_reg;
        clr_next       = clr_reg;
        tracked_next   = tracked_reg;
        port_next      = port_reg;
        now_next       = now_reg;
        res_port_next  = res_port_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_wr.en      = 1'b0;
        ram_wr.addr    = free_off[TRACK_IDX_W-1:0];
        ram_wr.data    = '{valid: 1'b1, stamp: now_reg};

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = clr_reg;
                ram_wr.data = '{valid: 1'b0, stamp: 32'd0};
                clr_next    = clr_reg + TRACK_IDX_W'(1);
                if (32'(clr_reg) == TRACK_DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    port_next  = s_tdata[15:0];
                    now_next   = s_tdata[47:16];
                    state_next = (s_tuser == REQ_FREE) ? ST_FREE : ST_START;
                end
            end
            ST_FREE:
            begin
                res_port_next = port_reg;
                res_ok_next   = (port_reg >= start_reg) &&
                                ({16'd0, free_off} < 32'(TRACK_DEPTH));
                ram_wr.en     = res_ok_next;
                state_next    = ST_RESULT;
            end
            ST_START:
            begin
                res_port_next = 16'd0;
                res_ok_next   = 1'b0;
                if (end_reg < start_reg)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    if (cursor_reg < start_reg || cursor_reg > end_reg)
                    begin
                        cursor_next = start_reg;
                    end
                    remain_next = {1'b0, end_reg} - {1'b0, start_reg} + 17'd1;
                    state_next  = ST_RD;
                end
            end
            ST_RD:
            begin
                tracked_next = ({16'd0, cur_off} < 32'(TRACK_DEPTH));
                state_next   = ST_CHK;
            end
            ST_CHK:
            begin
                cursor_next = (cursor_reg >= end_reg) ? start_reg : cursor_reg + 16'd1;
                remain_next = remain_reg - 17'd1;
                if (!held)
                begin
                    res_port_next = cursor_reg;
                    res_ok_next   = 1'b1;
                    state_next    = ST_RESULT;
                end
                else if (remain_reg == 17'd1)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_ok_reg, res_port_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_START:
                begin
                    start_next  = cfg_data[15:0];
                    cursor_next = cfg_data[15:0];
                end
                REG_BLOCK_END:   end_next  = cfg_data[15:0];
                REG_HOLD_TIME:   hold_next = cfg_data;
                default:         ;
            endcase
        end
    end

    `NPBA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `NPBA_ASSERT_NOW(a_cursor_in_block, clk, rst_n, state_reg == ST_CHK,
        cursor_reg >= start_reg && cursor_reg <= end_reg)
    `NPBA_ASSERT_NOW(a_pass_bounded, clk, rst_n, state_reg == ST_CHK, remain_reg != 17'd0)
    `NPBA_ASSERT_NOW(a_result_source, clk, rst_n, $rose(m_tvalid),
        $past(state_reg == ST_RESULT))

endmodule

`default_nettype wire
